@@ sv/gp2r_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gp2r_pkg
// Shared constants, widths and constant functions of the rotated Gaussian
// profile unit.
// ----------------------------------------------------------------------------
package gp2r_pkg;

  // Fixed point format of all Q values.
  localparam int FRAC_BITS = 16;
  localparam int QW        = 32;

  // Offsets from the center and their magnitudes after rotation.
  localparam int DW        = QW + 1;
  localparam int CW        = 32;
  localparam int PW        = DW + CW;
  localparam int MAG_W     = 36;

  // Axis ratio: quotient bits and clamp limit.
  localparam int QB        = FRAC_BITS + 7;
  localparam int WW        = 31;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int HI_W      = NUM_W - QB;
  localparam logic [QB-1:0] RATIO_LIM = QB'(1) << (FRAC_BITS + 6);

  // Exponent and power-of-two evaluation.
  localparam int SQ_W      = 2 * QB;
  localparam int EXP_W     = SQ_W + 1 - FRAC_BITS + 2;
  localparam int N_W       = EXP_W - FRAC_BITS;
  localparam int P_W       = 31;
  localparam int ANG_W     = 20;
  localparam int ANG_SHIFT = 30 - FRAC_BITS;

  // Q2.30 angle constants and CORDIC gain.
  localparam int AW = 35;
  localparam logic signed [AW-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [AW-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [AW-1:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [AW-1:0] CORDIC_K    = 35'sd652032874;
  localparam int CORDIC_STEPS = 30;

  // Register map, by word index.
  localparam int AIDX_W = 3;
  localparam logic [AIDX_W-1:0] REG_AMPLITUDE = 3'd0;
  localparam logic [AIDX_W-1:0] REG_CENTER_X  = 3'd1;
  localparam logic [AIDX_W-1:0] REG_CENTER_Y  = 3'd2;
  localparam logic [AIDX_W-1:0] REG_WIDTH_X   = 3'd3;
  localparam logic [AIDX_W-1:0] REG_WIDTH_Y   = 3'd4;
  localparam logic [AIDX_W-1:0] REG_ANGLE     = 3'd5;
  localparam logic [WW-1:0] WIDTH_RESET = WW'(3) << FRAC_BITS;

  // Truncated arctangent table in Q2.30.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd7;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Integer square root, used only at elaboration.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] val;
    logic [63:0] res;
    logic [63:0] bit_w;
    val   = v;
    res   = '0;
    bit_w = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (val >= res + bit_w) begin
        val = val - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Q2.30 factor 2^(-2^-k), built by repeated square roots of one half.
  function automatic logic [P_W-1:0] exp_root(input int k);
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int j = 1; j <= k; j++) begin
      t = isqrt64(t << 30);
    end
    return t[P_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/gp2r_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gp2r_if
// Valid/ready channels for pixel coordinates and profile values.
// ----------------------------------------------------------------------------
interface gp2r_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      x_pos;
  logic signed [31:0]      y_pos;
  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

interface gp2r_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      value;
  logic                    width_zero;
  modport source (output valid, output value, output width_zero, input ready);
  modport sink   (input valid, input value, input width_zero, output ready);
endinterface
`default_nettype wire

@@ sv/gp2r_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gp2r_cordic
// Iterative CORDIC that turns the angle register into cos and sin (Q2.30).
// ----------------------------------------------------------------------------
module gp2r_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [gp2r_pkg::ANG_W-1:0]    angle,
  output logic                                      idle,
  output logic signed [gp2r_pkg::CW-1:0]            cos_q,
  output logic signed [gp2r_pkg::CW-1:0]            sin_q
);

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_RED1 = 6'b000010,
    ST_RED2 = 6'b000100,
    ST_ITER = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_IDLE = 6'b100000
  } cs_state_t;

  cs_state_t state_r, state_nxt;
  logic signed [gp2r_pkg::AW-1:0] a_r, a_nxt;
  logic signed [gp2r_pkg::AW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic                           neg_r, neg_nxt;
  logic [4:0]                     i_r, i_nxt;
  logic signed [gp2r_pkg::CW-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [gp2r_pkg::AW-1:0] a_ext, xs, ys, at;

  assign a_ext = {{(gp2r_pkg::AW - gp2r_pkg::ANG_W){angle[gp2r_pkg::ANG_W-1]}}, angle};
  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign at    = gp2r_pkg::AW'(gp2r_pkg::atan_q30(i_r));

  // Range reduction, then one micro-rotation per cycle. a_r holds z.
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    neg_nxt   = neg_r;
    i_nxt     = i_r;
    c_nxt     = c_r;
    s_nxt     = s_r;
    unique case (state_r)
      ST_LOAD: begin
        a_nxt = a_ext <<< gp2r_pkg::ANG_SHIFT;
        if (a_nxt >= gp2r_pkg::Q30_TWO_PI) begin
          a_nxt = a_nxt - gp2r_pkg::Q30_TWO_PI;
        end else if (a_nxt <= -gp2r_pkg::Q30_TWO_PI) begin
          a_nxt = a_nxt + gp2r_pkg::Q30_TWO_PI;
        end
        state_nxt = ST_RED1;
      end
      ST_RED1: begin
        if (a_r > gp2r_pkg::Q30_PI) begin
          a_nxt = a_r - gp2r_pkg::Q30_TWO_PI;
        end else if (a_r < -gp2r_pkg::Q30_PI) begin
          a_nxt = a_r + gp2r_pkg::Q30_TWO_PI;
        end
        state_nxt = ST_RED2;
      end
      ST_RED2: begin
        neg_nxt = 1'b0;
        if (a_r > gp2r_pkg::Q30_HALF_PI) begin
          a_nxt   = a_r - gp2r_pkg::Q30_PI;
          neg_nxt = 1'b1;
        end else if (a_r < -gp2r_pkg::Q30_HALF_PI) begin
          a_nxt   = a_r + gp2r_pkg::Q30_PI;
          neg_nxt = 1'b1;
        end
        x_nxt     = gp2r_pkg::CORDIC_K;
        y_nxt     = '0;
        i_nxt     = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        if (a_r >= 0) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          a_nxt = a_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          a_nxt = a_r + at;
        end
        i_nxt = i_r + 5'd1;
        if (i_r == 5'(gp2r_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        c_nxt     = neg_r ? gp2r_pkg::CW'(-x_r) : gp2r_pkg::CW'(x_r);
        s_nxt     = neg_r ? gp2r_pkg::CW'(-y_r) : gp2r_pkg::CW'(y_r);
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_LOAD;
    endcase
    if (start) begin
      state_nxt = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
    a_r   <= a_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
    i_r   <= i_nxt;
    c_r   <= c_nxt;
    s_r   <= s_nxt;
  end

  assign idle  = (state_r == ST_IDLE);
  assign cos_q = c_r;
  assign sin_q = s_r;

endmodule
`default_nettype wire

@@ sv/gp2r_ratio.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gp2r_ratio
// Pipelined restoring divider for both axes: one quotient bit per stage,
// clamped to the axis ratio limit.
// ----------------------------------------------------------------------------
module gp2r_ratio (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              v_in,
  input  wire logic                              wz_in,
  input  wire logic [gp2r_pkg::MAG_W-1:0]        mag_x,
  input  wire logic [gp2r_pkg::MAG_W-1:0]        mag_y,
  input  wire logic [gp2r_pkg::WW-1:0]           width_x,
  input  wire logic [gp2r_pkg::WW-1:0]           width_y,
  output logic                                   v_out,
  output logic                                   wz_out,
  output logic [gp2r_pkg::QB-1:0]                ux,
  output logic [gp2r_pkg::QB-1:0]                uy
);

  localparam int QB = gp2r_pkg::QB;
  localparam int WW = gp2r_pkg::WW;

  logic                 v_r   [0:QB];
  logic                 wz_r  [0:QB];
  logic [WW-1:0]        rem_r [0:1][0:QB];
  logic [QB-1:0]        lo_r  [0:1][0:QB];
  logic [QB-1:0]        q_r   [0:1][0:QB];
  logic                 ovf_r [0:1][0:QB];
  logic [gp2r_pkg::NUM_W-1:0] num [0:1];
  logic [WW-1:0]        wd    [0:1];
  logic                 vo_r, wzo_r;
  logic [QB-1:0]        u_r   [0:1];

  assign num[0] = {mag_x, {gp2r_pkg::FRAC_BITS{1'b0}}};
  assign num[1] = {mag_y, {gp2r_pkg::FRAC_BITS{1'b0}}};
  assign wd[0]  = width_x;
  assign wd[1]  = width_y;

  // Setup stage: a quotient that needs more bits than kept is flagged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
    end
    if (en) begin
      wz_r[0] <= wz_in;
      for (int ax = 0; ax < 2; ax++) begin
        ovf_r[ax][0] <= (WW'(num[ax][gp2r_pkg::NUM_W-1:QB]) >= wd[ax]);
        rem_r[ax][0] <= WW'(num[ax][gp2r_pkg::NUM_W-1:QB]);
        lo_r[ax][0]  <= num[ax][QB-1:0];
        q_r[ax][0]   <= '0;
      end
    end
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [WW:0] trial [0:1];
    logic        ge    [0:1];
    always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
        trial[ax] = {rem_r[ax][k-1], lo_r[ax][k-1][QB-1]};
        ge[ax]    = (trial[ax] >= {1'b0, wd[ax]});
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        wz_r[k] <= wz_r[k-1];
        for (int ax = 0; ax < 2; ax++) begin
          rem_r[ax][k] <= ge[ax] ? WW'(trial[ax] - {1'b0, wd[ax]}) : WW'(trial[ax]);
          lo_r[ax][k]  <= {lo_r[ax][k-1][QB-2:0], 1'b0};
          q_r[ax][k]   <= {q_r[ax][k-1][QB-2:0], ge[ax]};
          ovf_r[ax][k] <= ovf_r[ax][k-1];
        end
      end
    end
  end

  // Clamp stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[QB];
    end
    if (en) begin
      wzo_r <= wz_r[QB];
      for (int ax = 0; ax < 2; ax++) begin
        u_r[ax] <= (ovf_r[ax][QB] || (q_r[ax][QB] > gp2r_pkg::RATIO_LIM)) ?
                   gp2r_pkg::RATIO_LIM : q_r[ax][QB];
      end
    end
  end

  assign v_out  = vo_r;
  assign wz_out = wzo_r;
  assign ux     = u_r[0];
  assign uy     = u_r[1];

endmodule
`default_nettype wire

@@ sv/gp2r_exp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gp2r_exp
// Squares and sums the axis ratios, then forms amplitude * 2^(-4*r2): one
// root factor per fraction bit, a final product and a rounding shift.
// ----------------------------------------------------------------------------
module gp2r_exp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          v_in,
  input  wire logic                          wz_in,
  input  wire logic [gp2r_pkg::QB-1:0]       ux,
  input  wire logic [gp2r_pkg::QB-1:0]       uy,
  input  wire logic signed [gp2r_pkg::QW-1:0] amplitude,
  output logic                               v_out,
  output logic                               wz_out,
  output logic signed [gp2r_pkg::QW-1:0]     value
);

  localparam int F   = gp2r_pkg::FRAC_BITS;
  localparam int PW  = gp2r_pkg::P_W;
  localparam int MW  = gp2r_pkg::QW + PW + 1;

  // Square stage.
  logic                        va_r, wza_r;
  logic [gp2r_pkg::SQ_W-1:0]   sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
    end
    if (en) begin
      wza_r <= wz_in;
      sqx_r <= ux * ux;
      sqy_r <= uy * uy;
    end
  end

  // Sum stage: split 4*r2 into integer and fraction parts.
  logic [gp2r_pkg::SQ_W:0]     sum;
  logic [gp2r_pkg::EXP_W-1:0]  e_q;
  logic [gp2r_pkg::N_W-1:0]    n_int;

  assign sum   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign e_q   = {sum[gp2r_pkg::SQ_W:F], 2'b00};
  assign n_int = e_q[gp2r_pkg::EXP_W-1:F];

  logic          v_r    [0:F];
  logic          wz_r   [0:F];
  logic          big_r  [0:F];
  logic [5:0]    n_r    [0:F];
  logic [F-1:0]  f_r    [0:F];
  logic [PW-1:0] p_r    [0:F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= va_r;
    end
    if (en) begin
      wz_r[0]  <= wza_r;
      big_r[0] <= (n_int >= gp2r_pkg::N_W'(33));
      n_r[0]   <= n_int[5:0];
      f_r[0]   <= e_q[F-1:0];
      p_r[0]   <= PW'(1) << 30;
    end
  end

  // One root factor per fraction bit, most significant first.
  for (genvar k = 1; k <= F; k++) begin : g_root
    localparam logic [PW-1:0] TK = gp2r_pkg::exp_root(k);
    logic [2*PW-1:0] prod;
    assign prod = p_r[k-1] * TK + ((2*PW)'(1) << 29);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        wz_r[k]  <= wz_r[k-1];
        big_r[k] <= big_r[k-1];
        n_r[k]   <= n_r[k-1];
        f_r[k]   <= f_r[k-1];
        p_r[k]   <= f_r[k-1][F-k] ? prod[PW+29:30] : p_r[k-1];
      end
    end
  end

  // Amplitude product stage.
  logic                    vm_r, wzm_r, bigm_r;
  logic [5:0]              nm_r;
  logic signed [MW-1:0]    m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= v_r[F];
    end
    if (en) begin
      wzm_r  <= wz_r[F];
      bigm_r <= big_r[F];
      nm_r   <= n_r[F];
      m_r    <= amplitude * $signed({1'b0, p_r[F]});
    end
  end

  // Rounding shift and saturation into the output register.
  logic [6:0]            sh;
  logic signed [MW:0]    rnd;
  logic signed [MW:0]    shifted;
  logic signed [gp2r_pkg::QW-1:0] sat;
  localparam logic signed [MW:0] QMAX = (MW+1)'(32'sh7fffffff);
  localparam logic signed [MW:0] QMIN = -(MW+1)'(64'sh80000000);

  always_comb begin
    sh      = 7'd30 + {1'b0, nm_r};
    rnd     = $signed({m_r[MW-1], m_r}) + ((MW+1)'(1) <<< (sh - 7'd1));
    shifted = rnd >>> sh;
    if (bigm_r || wzm_r) begin
      sat = '0;
    end else if (shifted > QMAX) begin
      sat = 32'sh7fffffff;
    end else if (shifted < QMIN) begin
      sat = 32'sh80000000;
    end else begin
      sat = shifted[gp2r_pkg::QW-1:0];
    end
  end

  logic                          vo_r, wzo_r;
  logic signed [gp2r_pkg::QW-1:0] val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vm_r;
    end
    if (en) begin
      wzo_r <= wzm_r;
      val_r <= sat;
    end
  end

  assign v_out  = vo_r;
  assign wz_out = wzo_r;
  assign value  = val_r;

endmodule
`default_nettype wire

@@ sv/gaussian_profile_2d_rotated_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_profile_2d_rotated_unit
// Rotated elliptical Gaussian: amplitude * 2^(-4*r2) per pixel coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one pixel word (x_pos, y_pos, signed Q16.16) per handshake;
//   out_ch returns one word (value, width_zero) per pixel, in order.
//   Registers are written through the APB-style cfg_ port, at byte address
//   4*index, while no pixel is in flight.
// Pipeline depth and throughput:
//   The pixel path has 48 register stages; the last one drives out_ch.valid.
//   The 25-stage divider (23 quotient bits) and the 20-stage exponential
//   (16 root factors) make up most of them. One pixel is accepted per cycle
//   while the output is taken and the CORDIC sequencer is idle.
// Reset and angle writes:
//   After reset and after each angle write, the CORDIC sequencer steps through
//   load, range reduction, micro-rotations and finish; in_ch.ready stays low.
// Stall:
//   When out_ch.ready is low with a word waiting, the whole pipeline holds
//   and in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gaussian_profile_2d_rotated_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  gp2r_in_if.sink            in_ch,
  gp2r_out_if.source         out_ch,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [4:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // Configuration registers.
  logic signed [gp2r_pkg::QW-1:0]    amp_r, cx_r, cy_r;
  logic [gp2r_pkg::WW-1:0]           wx_r, wy_r;
  logic signed [gp2r_pkg::ANG_W-1:0] ang_r;
  logic                              cfg_wr;
  logic [gp2r_pkg::AIDX_W-1:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= '0;
      cx_r  <= '0;
      cy_r  <= '0;
      wx_r  <= gp2r_pkg::WIDTH_RESET;
      wy_r  <= gp2r_pkg::WIDTH_RESET;
      ang_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        gp2r_pkg::REG_AMPLITUDE: amp_r <= cfg_pwdata;
        gp2r_pkg::REG_CENTER_X:  cx_r  <= cfg_pwdata;
        gp2r_pkg::REG_CENTER_Y:  cy_r  <= cfg_pwdata;
        gp2r_pkg::REG_WIDTH_X:   wx_r  <= cfg_pwdata[gp2r_pkg::WW-1:0];
        gp2r_pkg::REG_WIDTH_Y:   wy_r  <= cfg_pwdata[gp2r_pkg::WW-1:0];
        gp2r_pkg::REG_ANGLE:     ang_r <= cfg_pwdata[gp2r_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      gp2r_pkg::REG_AMPLITUDE: cfg_prdata = amp_r;
      gp2r_pkg::REG_CENTER_X:  cfg_prdata = cx_r;
      gp2r_pkg::REG_CENTER_Y:  cfg_prdata = cy_r;
      gp2r_pkg::REG_WIDTH_X:   cfg_prdata = {1'b0, wx_r};
      gp2r_pkg::REG_WIDTH_Y:   cfg_prdata = {1'b0, wy_r};
      gp2r_pkg::REG_ANGLE:     cfg_prdata = {12'd0, ang_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Cos and sin of the angle.
  logic                           cs_idle;
  logic signed [gp2r_pkg::CW-1:0] cos_q, sin_q;

  gp2r_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr && (cfg_idx == gp2r_pkg::REG_ANGLE)),
    .angle (ang_r),
    .idle  (cs_idle),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // The whole pipeline moves when the output register is free or taken.
  logic adv, out_v, out_wz;
  logic signed [gp2r_pkg::QW-1:0] out_val;

  assign adv         = !out_v || out_ch.ready;
  assign in_ch.ready = adv && cs_idle;

  // Stage 1: offsets from the center.
  logic                           v1_r, wz1_r;
  logic signed [gp2r_pkg::DW-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid && cs_idle;
    end
    if (adv) begin
      wz1_r <= (wx_r == '0) || (wy_r == '0);
      dx_r  <= gp2r_pkg::DW'(in_ch.x_pos) - gp2r_pkg::DW'(cx_r);
      dy_r  <= gp2r_pkg::DW'(in_ch.y_pos) - gp2r_pkg::DW'(cy_r);
    end
  end

  // Stage 2: rotation products.
  logic                           v2_r, wz2_r;
  logic signed [gp2r_pkg::PW-1:0] pxc_r, pxs_r, pyc_r, pys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      wz2_r <= wz1_r;
      pxc_r <= dx_r * cos_q;
      pxs_r <= dx_r * sin_q;
      pyc_r <= dy_r * cos_q;
      pys_r <= dy_r * sin_q;
    end
  end

  // Stage 3: rotated offsets and their magnitudes.
  localparam int RW = gp2r_pkg::PW - 30;
  logic signed [RW:0]               xr, yr;
  logic                             v3_r, wz3_r;
  logic [gp2r_pkg::MAG_W-1:0]       magx_r, magy_r;

  assign xr = $signed(pxc_r[gp2r_pkg::PW-1:30]) - $signed(pys_r[gp2r_pkg::PW-1:30]);
  assign yr = $signed(pyc_r[gp2r_pkg::PW-1:30]) + $signed(pxs_r[gp2r_pkg::PW-1:30]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      wz3_r  <= wz2_r;
      magx_r <= gp2r_pkg::MAG_W'(xr[RW] ? -xr : xr);
      magy_r <= gp2r_pkg::MAG_W'(yr[RW] ? -yr : yr);
    end
  end

  // Axis ratios.
  logic                      v4, wz4;
  logic [gp2r_pkg::QB-1:0]   ux, uy;

  gp2r_ratio u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .v_in    (v3_r),
    .wz_in   (wz3_r),
    .mag_x   (magx_r),
    .mag_y   (magy_r),
    .width_x (wx_r),
    .width_y (wy_r),
    .v_out   (v4),
    .wz_out  (wz4),
    .ux      (ux),
    .uy      (uy)
  );

  // Exponential and scaling; its last stage is the output register.
  gp2r_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .v_in      (v4),
    .wz_in     (wz4),
    .ux        (ux),
    .uy        (uy),
    .amplitude (amp_r),
    .v_out     (out_v),
    .wz_out    (out_wz),
    .value     (out_val)
  );

  assign out_ch.valid      = out_v;
  assign out_ch.value      = out_val;
  assign out_ch.width_zero = out_wz;

endmodule
`default_nettype wire

@@ sv/gp2r_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gp2r_checker
// Port-level checks of the rotated Gaussian profile unit.
// ----------------------------------------------------------------------------
module gp2r_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        out_width_zero
);

  // A waiting word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // A flagged zero width always gives a zero value.
  a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_width_zero |-> out_value == 32'd0)
    else $error("width_zero word with nonzero value");

  // Nothing is offered right after reset.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // While the output is stalled no new pixel word is taken.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("input accepted during output stall");

endmodule

bind gaussian_profile_2d_rotated_unit gp2r_checker u_gp2r_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value      (out_ch.value),
  .out_width_zero (out_ch.width_zero)
);
`default_nettype wire
